// ===== sv/ffha_pkg.sv =====
// Package for the first-fit heap allocator: payload structs, sizes, status codes.
// No dependencies.
`default_nettype none
package ffha_pkg;
    localparam int ARENA_BYTES  = 65536;
    localparam int HEADER_BYTES = 32;
    localparam int MAX_BLOCKS   = 64;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int OFF_W        = 16;
    localparam int SIZE_W       = 17;
    localparam int ADDR_W       = 48;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_FIT   = 2'd1;
    localparam logic [1:0] ST_IGNORED  = 2'd2;
    localparam logic [1:0] ST_NOT_BLK  = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] request_bytes;
        logic [ADDR_W-1:0] release_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] payload_address;
        logic [1:0]        status;
        logic [SIZE_W-1:0] bytes_in_use;
    } rsp_t;

    // one table entry: offset, payload size, free flag
    typedef struct packed {
        logic [OFF_W-1:0]  off;
        logic [SIZE_W-1:0] size;
        logic              free;
    } ent_t;

    localparam int ENT_W = $bits(ent_t);

    // controller to datapath
    typedef struct packed {
        logic            start;
        logic [IDX_W-1:0] rd_idx;
        logic            wr_en;
        logic [IDX_W-1:0] wr_idx;
        logic [2:0]      wr_sel;
        logic            hold_load;   // latch read entry into hold register
        logic            prev_load;
        logic [2:0]      acc_op;
        logic [1:0]      status;
        logic            rsp_load;
        logic            addr_zero;
        logic            cnt_inc;
        logic            cnt_dec;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic            fit;
        logic            split_ok;
        logic            match;
        logic            rd_free;
        logic            is_null;
        logic            op;
        logic [CNT_W-1:0] count;
    } sts_t;

    localparam logic [2:0] WR_SPLIT_HEAD = 3'd0; // entry i shrunk and used
    localparam logic [2:0] WR_SHIFT      = 3'd1; // write held entry
    localparam logic [2:0] WR_NEW_FREE   = 3'd2; // split remainder
    localparam logic [2:0] WR_USED_WHOLE = 3'd3; // entry i used whole
    localparam logic [2:0] WR_ACC        = 3'd4; // write accumulator entry
    localparam logic [2:0] WR_INIT       = 3'd5;

    localparam logic [2:0] ACC_NONE   = 3'd0;
    localparam logic [2:0] ACC_LOAD   = 3'd1; // acc = read entry, marked free
    localparam logic [2:0] ACC_MERGE  = 3'd2; // acc.size += HDR + read.size
    localparam logic [2:0] ACC_PREV   = 3'd3; // acc = prev + HDR + acc.size
endpackage
`default_nettype wire

// ===== sv/first_fit_heap_allocator.sv =====
// First-fit heap allocator top level: config register, controller and datapath.
// Depends on ffha_pkg, ffha_ctrl, ffha_dp.
// Each request walks the table one entry per cycle; entries are shifted on a split or merge.
// One item at a time; the next is taken only after the result is accepted.
// Reset: asynchronous, active low; after reset the table is first written with the
// single free block, then items are accepted.
`default_nettype none
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire req_t              in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rsp_t                   out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ADDR_W-1:0] cfg_data
);
    logic [ADDR_W-1:0] base_reg;
    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            base_reg <= '0;
        else if (cfg_valid)
            base_reg <= cfg_data;
    end

    ffha_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
    );

    ffha_dp u_dp (
        .clk(clk), .rst_n(rst_n), .base(base_reg), .req(in_data),
        .cmd(cmd), .sts(sts), .rsp(out_data)
    );
endmodule
`default_nettype wire

// ===== sv/ffha_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== sv/ffha_dp.sv =====
// Datapath of the heap allocator: block table RAM, accumulators, address math.
// Depends on ffha_pkg and ffha_ram.
`default_nettype none
module ffha_dp
    import ffha_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [ADDR_W-1:0] base,
    input  wire req_t              req,
    input  wire cmd_t              cmd,
    output sts_t                   sts,
    output rsp_t                   rsp
);
    logic [IDX_W-1:0]  raddr;
    ent_t              rd, wdata;
    ent_t              hold_reg, acc_reg, prev_reg;
    req_t              req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SIZE_W-1:0] used_reg;
    logic [SIZE_W:0]   asize;       // one bit wider: a request near the top rounds past it
    logic [ADDR_W-1:0] rel_off;
    logic [ADDR_W-1:0] addr_reg;
    logic [1:0]        stat_reg;

    assign raddr = cmd.rd_idx;

    ffha_ram #(.WIDTH(ENT_W), .DEPTH(MAX_BLOCKS)) u_tab (
        .clk(clk), .we(cmd.wr_en), .waddr(cmd.wr_idx), .wdata(wdata),
        .raddr(raddr), .rdata(rd)
    );

    assign asize   = ({1'b0, req_reg.request_bytes} + (SIZE_W+1)'(7)) & ~(SIZE_W+1)'(7);
    assign rel_off = req_reg.release_address - base - ADDR_W'(HEADER_BYTES);

    always_comb
    begin
        wdata = hold_reg;
        case (cmd.wr_sel)
            WR_SPLIT_HEAD: wdata = '{off: rd.off, size: asize[SIZE_W-1:0], free: 1'b0};
            WR_SHIFT:      wdata = hold_reg;
            WR_NEW_FREE:   wdata = '{off: rd.off + OFF_W'(HEADER_BYTES) + asize[OFF_W-1:0],
                                     size: rd.size - asize[SIZE_W-1:0]
                                           - SIZE_W'(HEADER_BYTES),
                                     free: 1'b1};
            WR_USED_WHOLE: wdata = '{off: rd.off, size: rd.size, free: 1'b0};
            WR_ACC:        wdata = acc_reg;
            WR_INIT:       wdata = '{off: '0, size: SIZE_W'(ARENA_BYTES - HEADER_BYTES),
                                     free: 1'b1};
            default:       wdata = hold_reg;
        endcase
    end

    assign sts.fit      = rd.free && ({1'b0, rd.size} >= asize);
    assign sts.split_ok = ({1'b0, rd.size} > asize + (SIZE_W+1)'(HEADER_BYTES + 8))
                          && (count_reg < CNT_W'(MAX_BLOCKS));
    assign sts.match    = (rel_off == ADDR_W'(rd.off));
    assign sts.rd_free  = rd.free;
    assign sts.is_null  = (req_reg.release_address == '0);
    assign sts.op       = req_reg.operation;
    assign sts.count    = count_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
            req_reg <= req;
        if (cmd.hold_load)
            hold_reg <= rd;
        if (cmd.prev_load)
            prev_reg <= rd;
        case (cmd.acc_op)
            ACC_LOAD:  acc_reg <= '{off: rd.off, size: rd.size, free: 1'b1};
            ACC_MERGE: acc_reg.size <= acc_reg.size + SIZE_W'(HEADER_BYTES) + rd.size;
            ACC_PREV:  acc_reg <= '{off: prev_reg.off,
                                    size: prev_reg.size + SIZE_W'(HEADER_BYTES) + acc_reg.size,
                                    free: 1'b1};
            default:   acc_reg <= acc_reg;
        endcase
        if (cmd.rsp_load)
        begin
            stat_reg <= cmd.status;
            addr_reg <= cmd.addr_zero ? '0
                      : base + ADDR_W'(rd.off) + ADDR_W'(HEADER_BYTES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            used_reg  <= '0;
        end
        else
        begin
            if (cmd.cnt_inc)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.cnt_dec)
                count_reg <= count_reg - CNT_W'(1);
            // used total moves on the response load of an ok alloc/free
            if (cmd.rsp_load && cmd.status == ST_OK && !cmd.addr_zero)
                used_reg <= used_reg + (cmd.wr_sel == WR_SPLIT_HEAD ? asize[SIZE_W-1:0]
                                                                    : rd.size);
            else if (cmd.rsp_load && cmd.status == ST_OK && cmd.addr_zero
                     && used_reg >= rd.size)
                used_reg <= used_reg - rd.size;
        end
    end

    assign rsp.payload_address = addr_reg;
    assign rsp.status          = stat_reg;
    assign rsp.bytes_in_use    = used_reg;
endmodule
`default_nettype wire

// ===== sv/ffha_ctrl.sv =====
// Controller of the heap allocator: search, shift and merge sequencing.
// Depends on ffha_pkg.
`default_nettype none
module ffha_ctrl
    import ffha_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  wire logic out_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);
    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_RD     = 4'd2;  // read issued, data next cycle
    localparam logic [3:0] S_CHK    = 4'd3;  // examine entry i
    localparam logic [3:0] S_SHRD   = 4'd4;  // insert: read j-1
    localparam logic [3:0] S_SHWR   = 4'd5;  // insert: write j
    localparam logic [3:0] S_SPLIT  = 4'd6;  // reread i, write head and remainder
    localparam logic [3:0] S_SPLIT2 = 4'd7;
    localparam logic [3:0] S_NXT    = 4'd8;  // free: check i+1
    localparam logic [3:0] S_PRV    = 4'd9;  // free: check i-1
    localparam logic [3:0] S_RMRD   = 4'd10; // remove: read j+rm
    localparam logic [3:0] S_RMWR   = 4'd11; // remove: write j
    localparam logic [3:0] S_FIN    = 4'd12; // merge previous entry, write merged entry
    localparam logic [3:0] S_OUT    = 4'd13;
    localparam logic [3:0] S_RESP   = 4'd14; // second block count decrement

    logic [3:0]       state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0] rm_reg, rm_next;     // count of removals pending
    logic             merge_prev_reg, merge_prev_next;
    logic             ov_reg, ov_next;

    // hold the input while busy or while the previous result still waits
    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg; i_next = i_reg; j_next = j_reg; rm_next = rm_reg;
        merge_prev_next = merge_prev_reg;
        ov_next = ov_reg && out_stall;
        cmd = '0;
        cmd.rd_idx = i_reg;
        cmd.wr_idx = j_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.wr_en = 1'b1; cmd.wr_idx = '0; cmd.wr_sel = WR_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
                if (in_valid && !ov_reg)
                begin
                    cmd.start = 1'b1; i_next = '0; rm_next = '0; merge_prev_next = 1'b0;
                    cmd.rd_idx = '0;
                    state_next = S_CHK;
                end
            S_RD:
                state_next = S_CHK;
            S_CHK:
            begin
                if (sts.op == OP_FREE && sts.is_null)
                begin
                    state_next = S_OUT;
                    cmd.rsp_load = 1'b1; cmd.addr_zero = 1'b1; cmd.status = ST_IGNORED;
                end
                else if (sts.op == OP_ALLOC && sts.fit)
                begin
                    if (sts.split_ok)
                    begin
                        // open slot i+1 by shifting entries up from the tail
                        j_next = sts.count[IDX_W-1:0];
                        cmd.rd_idx = sts.count[IDX_W-1:0] - IDX_W'(1);
                        state_next = (sts.count[IDX_W-1:0] - IDX_W'(1) == i_reg)
                                   ? S_SPLIT : S_SHRD;
                        if (sts.count[IDX_W-1:0] - IDX_W'(1) == i_reg)
                            cmd.rd_idx = i_reg;
                    end
                    else
                    begin
                        cmd.wr_en = 1'b1; cmd.wr_idx = i_reg; cmd.wr_sel = WR_USED_WHOLE;
                        cmd.rsp_load = 1'b1; cmd.status = ST_OK;
                        cmd.wr_sel = WR_USED_WHOLE;
                        state_next = S_OUT;
                    end
                end
                else if (sts.op == OP_FREE && sts.match)
                begin
                    if (sts.rd_free)
                    begin
                        cmd.rsp_load = 1'b1; cmd.addr_zero = 1'b1; cmd.status = ST_IGNORED;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        cmd.acc_op = ACC_LOAD;
                        cmd.rsp_load = 1'b1; cmd.addr_zero = 1'b1; cmd.status = ST_OK;
                        // next entry
                        if ({1'b0, i_reg} + CNT_W'(1) < sts.count)
                        begin
                            cmd.rd_idx = i_reg + IDX_W'(1);
                            state_next = S_NXT;
                        end
                        else if (i_reg != '0)
                        begin
                            cmd.rd_idx = i_reg - IDX_W'(1);
                            state_next = S_PRV;
                        end
                        else
                            state_next = S_FIN;
                    end
                end
                else if ({1'b0, i_reg} + CNT_W'(1) < sts.count)
                begin
                    i_next = i_reg + IDX_W'(1);
                    cmd.rd_idx = i_reg + IDX_W'(1);
                end
                else
                begin
                    cmd.rsp_load = 1'b1; cmd.addr_zero = 1'b1;
                    cmd.status = (sts.op == OP_ALLOC) ? ST_NO_FIT : ST_NOT_BLK;
                    state_next = S_OUT;
                end
            end
            S_SHRD:
            begin
                // rd holds entry j-1; write it to j
                cmd.hold_load = 1'b1;
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                cmd.wr_en = 1'b1; cmd.wr_idx = j_reg; cmd.wr_sel = WR_SHIFT;
                j_next = j_reg - IDX_W'(1);
                if (j_reg - IDX_W'(2) == i_reg)
                begin
                    cmd.rd_idx = i_reg;
                    state_next = S_SPLIT;
                end
                else
                begin
                    cmd.rd_idx = j_reg - IDX_W'(2);
                    state_next = S_SHRD;
                end
            end
            S_SPLIT:
            begin
                cmd.wr_en = 1'b1; cmd.wr_idx = i_reg + IDX_W'(1); cmd.wr_sel = WR_NEW_FREE;
                cmd.cnt_inc = 1'b1;
                cmd.rd_idx = i_reg;
                state_next = S_SPLIT2;
            end
            S_SPLIT2:
            begin
                cmd.wr_en = 1'b1; cmd.wr_idx = i_reg; cmd.wr_sel = WR_SPLIT_HEAD;
                cmd.rsp_load = 1'b1; cmd.status = ST_OK;
                state_next = S_OUT;
            end
            S_NXT:
            begin
                if (sts.rd_free)
                begin
                    cmd.acc_op = ACC_MERGE;
                    rm_next = CNT_W'(1);
                    j_next = i_reg + IDX_W'(1);
                end
                if (i_reg != '0)
                begin
                    cmd.rd_idx = i_reg - IDX_W'(1);
                    state_next = S_PRV;
                end
                else
                    state_next = S_FIN;
            end
            S_PRV:
            begin
                if (sts.rd_free)
                begin
                    cmd.prev_load = 1'b1;
                    merge_prev_next = 1'b1;
                end
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (merge_prev_reg)
                begin
                    cmd.acc_op = ACC_PREV;
                    merge_prev_next = 1'b0;
                    i_next = i_reg - IDX_W'(1);
                    j_next = i_reg;
                    rm_next = rm_reg + CNT_W'(1);
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.wr_en = 1'b1; cmd.wr_idx = i_reg; cmd.wr_sel = WR_ACC;
                    j_next = i_reg + IDX_W'(1);
                    cmd.rd_idx = i_reg + IDX_W'(1) + rm_reg[IDX_W-1:0];
                    if (rm_reg == '0)
                        state_next = S_OUT;
                    else if ({1'b0, i_reg} + CNT_W'(1) + rm_reg >= sts.count)
                    begin
                        state_next = S_RMWR; // nothing to shift; just shrink
                    end
                    else
                        state_next = S_RMRD;
                end
            end
            S_RMRD:
            begin
                cmd.hold_load = 1'b1;
                cmd.wr_sel = WR_SHIFT;
                state_next = S_RMWR;
            end
            S_RMWR:
            begin
                if ({1'b0, j_reg} + rm_reg < sts.count)
                begin
                    cmd.wr_en = 1'b1; cmd.wr_idx = j_reg; cmd.wr_sel = WR_SHIFT;
                end
                j_next = j_reg + IDX_W'(1);
                if ({1'b0, j_reg} + CNT_W'(1) + rm_reg < sts.count)
                begin
                    cmd.rd_idx = j_reg + IDX_W'(1) + rm_reg[IDX_W-1:0];
                    state_next = S_RMRD;
                end
                else
                begin
                    cmd.cnt_dec = 1'b1;
                    rm_next = rm_reg - CNT_W'(1);
                    state_next = (rm_reg == CNT_W'(1)) ? S_OUT : S_RESP;
                end
            end
            S_RESP:
            begin
                cmd.cnt_dec = 1'b1;
                rm_next = '0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT; i_reg <= '0; j_reg <= '0; rm_reg <= '0;
            merge_prev_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next; i_reg <= i_next; j_reg <= j_next; rm_reg <= rm_next;
            merge_prev_reg <= merge_prev_next;
            ov_reg <= ov_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> sts.count != '0)
        else $error("block count reached zero");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> sts.count < CNT_W'(MAX_BLOCKS))
        else $error("split with full table");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> ov_reg)
        else $error("result dropped while stalled");
endmodule
`default_nettype wire
